// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the message deframer.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/lpmd_pkg.sv =====
// Shared types, codes and constants of the length-prefixed message deframer.
// No dependencies.
package lpmd_pkg;

    // frame layout
    localparam int HEADER_BYTES    = 17;
    localparam int HDR_FIELD_BYTES = 13;  // index, code, value, hour, minute, second
    localparam int MODE_BYTES      = 3;
    localparam int CNT_W           = $clog2(HEADER_BYTES);

    localparam logic [CNT_W-1:0] HDR_LAST   = CNT_W'(HEADER_BYTES - 1);
    localparam logic [CNT_W-1:0] HDR_FIELDS = CNT_W'(HDR_FIELD_BYTES);
    localparam logic [CNT_W-1:0] MODE_LAST  = CNT_W'(MODE_BYTES - 1);

    localparam logic [23:0] MODE_PUT = 24'h707574;  // "put"
    localparam logic [23:0] MODE_GET = 24'h676574;  // "get"

    localparam logic [7:0] MAX_HOUR   = 8'd23;
    localparam logic [7:0] MAX_MINUTE = 8'd59;
    localparam logic [7:0] MAX_SECOND = 8'd59;

    localparam logic [15:0] MAX_TEXT_RESET = 16'hFFFF;
    localparam logic [31:0] STOP_LENGTH    = 32'd4;

    // stop-word matcher: 0..3 matched so far, 4 full match, 5 mismatch
    localparam logic [2:0] MATCH_NONE = 3'd0;
    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd5;

    // register file
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_MAX_TEXT = '0;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MODE   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;
    localparam logic [1:0] ERR_TIME   = 2'd3;

    typedef enum logic [2:0] {
        PH_MODE,
        PH_HEADER,
        PH_TEXT,
        PH_HALT,
        PH_GET
    } t_phase;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        msg_index;
        logic [15:0]        sender_code;
        logic signed [31:0] signed_value;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [15:0]        text_length;
        logic [7:0]         text_byte;
        logic               last;
        logic               stop_seen;
        logic [1:0]         error_code;
    } t_result;

    typedef struct packed {
        t_phase phase;
    } t_status;

    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h73;  // s
            2'd1:    c = 8'h74;  // t
            2'd2:    c = 8'h6F;  // o
            default: c = 8'h70;  // p
        endcase
        return c;
    endfunction

endpackage

// ===== sv/lpmd_parser.sv =====
// Byte-stream parser of the message deframer: mode check, header, text.
// Depends on lpmd_pkg.
module lpmd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_restart,
    input  logic [15:0]       i_max_text_length,
    output logic              o_has_result,
    output lpmd_pkg::t_result o_result,
    output lpmd_pkg::t_status o_status
);
    import lpmd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [23:0]           r_mode,  n_mode;
    logic [103:0]          r_hdr,   n_hdr;
    logic [31:0]           r_len,   n_len;
    logic [15:0]           r_rem,   n_rem;
    logic [2:0]            r_match, n_match;

    logic [23:0] w_mode_full;
    logic [31:0] w_len_full;
    logic        w_mode_end, w_hdr_end;
    logic        w_too_long, w_bad_time;
    logic [15:0] w_rem_dec;
    logic [2:0]  w_match_next;
    logic        w_stop;

    assign w_mode_full = {r_mode[15:0], i_data_byte};
    assign w_len_full  = {r_len[23:0], i_data_byte};
    assign w_mode_end  = (r_count == MODE_LAST);
    assign w_hdr_end   = (r_count == HDR_LAST);
    assign w_too_long  = (w_len_full > {16'd0, i_max_text_length});
    assign w_bad_time  = (r_hdr[23:16] > MAX_HOUR) || (r_hdr[15:8] > MAX_MINUTE)
                      || (r_hdr[7:0] > MAX_SECOND);
    assign w_rem_dec   = r_rem - 16'd1;
    assign w_match_next = (r_match < MATCH_FULL && i_data_byte == stop_char(r_match[1:0]))
                        ? r_match + 3'd1 : MATCH_FAIL;
    assign w_stop      = (r_len == STOP_LENGTH) && (w_match_next == MATCH_FULL);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_mode  = r_mode;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_rem   = r_rem;
        n_match = r_match;
        if (i_accept) begin
            if (i_restart) begin
                n_phase = PH_MODE;
                n_count = '0;
                n_mode  = '0;
                n_hdr   = '0;
                n_len   = '0;
                n_rem   = '0;
                n_match = MATCH_NONE;
            end else begin
                unique case (r_phase)
                    PH_MODE: begin
                        n_mode = w_mode_full;
                        if (w_mode_end) begin
                            n_count = '0;
                            if (w_mode_full == MODE_PUT) begin
                                n_phase = PH_HEADER;
                            end else if (w_mode_full == MODE_GET) begin
                                n_phase = PH_GET;
                            end else begin
                                n_phase = PH_HALT;
                            end
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    PH_HEADER: begin
                        if (r_count < HDR_FIELDS) begin
                            n_hdr = {r_hdr[95:0], i_data_byte};
                        end else begin
                            n_len = w_len_full;
                        end
                        if (w_hdr_end) begin
                            n_count = '0;
                            if (w_too_long || w_bad_time) begin
                                n_phase = PH_HALT;
                            end else begin
                                n_rem   = w_len_full[15:0];
                                n_match = MATCH_NONE;
                                if (w_len_full[15:0] == 16'd0) begin
                                    n_len = '0;
                                end else begin
                                    n_phase = PH_TEXT;
                                end
                            end
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    PH_TEXT: begin
                        n_match = w_match_next;
                        n_rem   = w_rem_dec;
                        if (w_rem_dec == 16'd0) begin
                            n_phase = w_stop ? PH_HALT : PH_HEADER;
                            n_len   = '0;
                            n_match = MATCH_NONE;
                        end
                    end
                    default: begin
                        // halted or get mode: bytes are dropped
                    end
                endcase
            end
        end
    end

    // result
    always_comb begin
        o_result     = '0;
        o_has_result = 1'b0;
        if (i_accept && !i_restart) begin
            unique case (r_phase)
                PH_MODE: begin
                    if (w_mode_end && w_mode_full != MODE_PUT && w_mode_full != MODE_GET) begin
                        o_has_result        = 1'b1;
                        o_result.kind       = KIND_ERROR;
                        o_result.error_code = ERR_MODE;
                    end
                end
                PH_HEADER: begin
                    if (w_hdr_end) begin
                        o_has_result = 1'b1;
                        if (w_too_long) begin
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_LENGTH;
                        end else if (w_bad_time) begin
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_TIME;
                        end else begin
                            o_result.kind         = KIND_HEADER;
                            o_result.msg_index    = r_hdr[103:72];
                            o_result.sender_code  = r_hdr[71:56];
                            o_result.signed_value = r_hdr[55:24];
                            o_result.hour         = r_hdr[20:16];
                            o_result.minute       = r_hdr[13:8];
                            o_result.second       = r_hdr[5:0];
                            o_result.text_length  = w_len_full[15:0];
                            o_result.last         = (w_len_full[15:0] == 16'd0);
                        end
                    end
                end
                PH_TEXT: begin
                    o_has_result       = 1'b1;
                    o_result.kind      = KIND_TEXT;
                    o_result.text_byte = i_data_byte;
                    o_result.last      = (w_rem_dec == 16'd0);
                    o_result.stop_seen = (w_rem_dec == 16'd0) && w_stop;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MODE;
            r_count <= '0;
            r_mode  <= '0;
            r_hdr   <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_match <= MATCH_NONE;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_mode  <= n_mode;
            r_hdr   <= n_hdr;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_match <= n_match;
        end
    end

endmodule

// ===== sv/length_prefixed_message_deframer_top.sv =====
// Top level of the length-prefixed message deframer; uses lpmd_pkg, lpmd_parser.
// Throughput: one byte per clock while o_stall is low, whatever the phase.
// Results go through the output register, parked in the skid while it is held.
// A two-entry output stage (result register plus skid register) sets the stall.
// Reset (synchronous, active low): parser back to mode check, outputs empty,
// max_text_length back to 65535.
module length_prefixed_message_deframer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_restart,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [31:0]                 o_msg_index,
    output logic [15:0]                 o_sender_code,
    output logic signed [31:0]          o_signed_value,
    output logic [4:0]                  o_hour,
    output logic [5:0]                  o_minute,
    output logic [5:0]                  o_second,
    output logic [15:0]                 o_text_length,
    output logic [7:0]                  o_text_byte,
    output logic                        o_last,
    output logic                        o_stop_seen,
    output logic [1:0]                  o_error_code,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpmd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    `include "assert_macros.svh"
    import lpmd_pkg::*;

    // config register
    logic [15:0] r_max_text;
    logic        w_cfg_wr;
    logic        w_cfg_hit;

    // output stage
    t_result r_out,  n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;

    logic    w_accept;
    logic    w_out_fire;
    logic    w_has_result;
    t_result w_result;
    t_status w_status;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[ADDR_W-1:2] == REG_MAX_TEXT);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_cfg_hit ? {16'd0, r_max_text} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_text <= MAX_TEXT_RESET;
        end else if (w_cfg_wr && w_cfg_hit) begin
            r_max_text <= pwdata[15:0];
        end
    end

    // ---------------- parser ----------------
    // Stall only once the skid holds a word: the result register can still
    // drain while the next byte is taken.
    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;

    lpmd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_data_byte      (i_data_byte),
        .i_restart        (i_restart),
        .i_max_text_length(r_max_text),
        .o_has_result     (w_has_result),
        .o_result         (w_result),
        .o_status         (w_status)
    );

    // ---------------- output register + skid ----------------
    assign w_out_fire = r_out_valid && !i_stall;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_fire || !r_out_valid) begin
            // output slot frees up: oldest word first (skid, then new result)
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_result;
                n_out_valid = w_has_result;
            end
        end else if (w_has_result) begin
            // output held downstream: park the new word
            n_skid       = w_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_msg_index    = r_out.msg_index;
    assign o_sender_code  = r_out.sender_code;
    assign o_signed_value = r_out.signed_value;
    assign o_hour         = r_out.hour;
    assign o_minute       = r_out.minute;
    assign o_second       = r_out.second;
    assign o_text_length  = r_out.text_length;
    assign o_text_byte    = r_out.text_byte;
    assign o_last         = r_out.last;
    assign o_stop_seen    = r_out.stop_seen;
    assign o_error_code   = r_out.error_code;

    // ---------------- checks ----------------
    `ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, w_accept && i_restart, w_status.phase == PH_MODE)
    `ASSERT_IMPLIES(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_IMPLIES(a_stop_on_last_text, i_clk, i_rst_n, o_valid && o_stop_seen, o_last && (o_kind == KIND_TEXT))
    `ASSERT_IMPLIES(a_quiet_phases, i_clk, i_rst_n, w_accept && (w_status.phase == PH_HALT || w_status.phase == PH_GET), !w_has_result)

endmodule
